@@ src/bedo_pkg.sv @@
// Shared types, widths and constants of the bass energy onset detector.
`default_nettype none

package bedo_pkg;

  // Widths of the fixed-point datapath.
  localparam int SAMPLE_W   = 16;
  localparam int MONO_W     = 32;  // Q16.16 mono and filter states
  localparam int POLE_W     = 49;  // filter difference times alpha
  localparam int SQUARE_W   = 64;
  localparam int ENERGY_W   = 39;  // Q31.8 frame energy
  localparam int BASE_W     = 47;  // Q31.16 baselines
  localparam int SCALE_W    = 63;  // baseline difference times half a coefficient
  localparam int SUM_W      = 50;  // saturating chunk energy sum
  localparam int SINCE_W    = 32;  // frames since the last onset
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Defaults and fixed limits.
  localparam int MAX_CHUNK_FRAMES_DEF = 4096;
  localparam int MAX_CHANNELS         = 2;
  localparam int QUEUE_DEPTH          = 2;
  localparam int QUEUE_IDX_W          = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W          = $clog2(QUEUE_DEPTH + 1);

  // Register reset values.
  localparam logic [1:0]  CHANNEL_COUNT_RST     = 2'd2;
  localparam logic [15:0] LOWPASS_COEFF_RST     = 16'd1367;
  localparam logic [31:0] BASELINE_COEFF_RST    = 32'd97391;
  localparam logic [15:0] ONSET_RATIO_RST       = 16'd384;
  localparam logic [15:0] REARM_RATIO_RST       = 16'd282;
  localparam logic [30:0] SILENCE_FLOOR_RST     = 31'd1000;
  localparam logic [19:0] REFRACTORY_FRAMES_RST = 20'd4410;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT     = 3'd0,
    REG_LOWPASS_COEFF     = 3'd1,
    REG_BASELINE_COEFF    = 3'd2,
    REG_ONSET_RATIO       = 3'd3,
    REG_REARM_RATIO       = 3'd4,
    REG_SILENCE_FLOOR     = 3'd5,
    REG_REFRACTORY_FRAMES = 3'd6
  } reg_index_t;

  // Configuration as seen by the front and back ends.
  typedef struct packed {
    logic [1:0]  channel_count;
    logic [15:0] lowpass_coeff;
    logic [31:0] baseline_coeff;
    logic [15:0] onset_ratio;
    logic [15:0] rearm_ratio;
    logic [30:0] silence_floor;
    logic [19:0] refractory_frames;
  } cfg_t;

  // One mixed frame handed from the front end to the back end.
  typedef struct packed {
    logic signed [MONO_W-1:0] mono;
    logic                     last;
  } frame_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_ACC1,
    ST_MUL2,
    ST_ACC2,
    ST_SQR,
    ST_ENERGY,
    ST_DIFF,
    ST_MULB,
    ST_SCALE,
    ST_BUPD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CMP_MUL,
    ST_DECIDE
  } back_state_t;

endpackage

`default_nettype wire

@@ src/bedo_front.sv @@
// Front end: accepts frames, mixes them to mono and queues them for the back end.
`default_nettype none

module bedo_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [bedo_pkg::SAMPLE_W-1:0] sample_a,
  input  wire logic signed [bedo_pkg::SAMPLE_W-1:0] sample_b,
  input  wire logic                                 last_frame,
  input  wire logic [1:0]                           channel_count,
  output logic                                      fr_valid,
  input  wire logic                                 fr_ready,
  output bedo_pkg::frame_t                          frame
);

  bedo_pkg::frame_t                   queue [bedo_pkg::QUEUE_DEPTH];
  logic [bedo_pkg::QUEUE_IDX_W-1:0]   wr_ptr;
  logic [bedo_pkg::QUEUE_IDX_W-1:0]   rd_ptr;
  logic [bedo_pkg::QUEUE_CNT_W-1:0]   fill;
  logic                               wr_en;
  logic                               rd_en;
  logic signed [bedo_pkg::SAMPLE_W:0] pair_sum;
  logic                               single_channel;
  bedo_pkg::frame_t                   incoming;

  // Mono mix in Q16.16: one channel is shifted up a full word, two are summed and halved.
  always_comb begin
    pair_sum       = {sample_a[bedo_pkg::SAMPLE_W-1], sample_a}
                   + {sample_b[bedo_pkg::SAMPLE_W-1], sample_b};
    single_channel = (channel_count == 2'd1) || (bedo_pkg::MAX_CHANNELS == 1);
    incoming.last  = last_frame;
    if (single_channel) begin
      incoming.mono = {sample_a, 16'd0};
    end else begin
      incoming.mono = {pair_sum, 15'd0};
    end
  end

  // Queue handshakes.
  assign full     = (fill == bedo_pkg::QUEUE_CNT_W'(bedo_pkg::QUEUE_DEPTH));
  assign fr_valid = (fill != '0);
  assign frame    = queue[rd_ptr];
  assign wr_en    = push && !full;
  assign rd_en    = fr_valid && fr_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= incoming;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        if (wr_ptr == bedo_pkg::QUEUE_IDX_W'(bedo_pkg::QUEUE_DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
      if (rd_en) begin
        if (rd_ptr == bedo_pkg::QUEUE_IDX_W'(bedo_pkg::QUEUE_DEPTH - 1)) begin
          rd_ptr <= '0;
        end else begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // An accepted word is waiting for the back end on the following cycle.
  a_accept_queued : assert property (@(posedge clk) disable iff (rst)
    wr_en |=> fr_valid)
    else $error("accepted word missing from the queue");

endmodule

`default_nettype wire

@@ src/bedo_div.sv @@
// Restoring divider that retires one quotient bit a cycle.
`default_nettype none

module bedo_div #(
  parameter int DIVIDEND_W = 50,
  parameter int DIVISOR_W  = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [STEP_W-1:0]     steps;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] shreg;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh  = {rem, shreg[DIVIDEND_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    fits    = (rem_sh >= {1'b0, divisor});
  end

  assign done     = busy && (steps == '0);
  assign quotient = shreg;

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(DIVIDEND_W);
    end else if (busy) begin
      if (steps == '0) begin
        busy <= 1'b0;
      end else begin
        steps <= steps - 1'b1;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
    end else if (busy && (steps != '0)) begin
      rem   <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      shreg <= {shreg[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ src/bedo_back.sv @@
// Back end: filters, energy, baseline and chunk decision, one step a cycle.
`default_nettype none

module bedo_back #(
  parameter int MAX_CHUNK_FRAMES = bedo_pkg::MAX_CHUNK_FRAMES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bedo_pkg::cfg_t   cfg,
  input  wire logic             fr_valid,
  output logic                  fr_ready,
  input  wire bedo_pkg::frame_t frame,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output logic                  res_fired
);

  localparam int CNT_W = $clog2(MAX_CHUNK_FRAMES + 1);
  localparam int MONO_W = bedo_pkg::MONO_W;
  localparam int POLE_W = bedo_pkg::POLE_W;
  localparam int BASE_W = bedo_pkg::BASE_W;
  localparam int SUM_W  = bedo_pkg::SUM_W;
  localparam int SCL_W  = bedo_pkg::SCALE_W;
  localparam int LHS_W  = bedo_pkg::SUM_W + 16;

  bedo_pkg::back_state_t state, state_next;

  // Model state.
  logic signed [MONO_W-1:0]         s1, s2;
  logic [SUM_W-1:0]                 sum;
  logic [CNT_W-1:0]                 count;
  logic [BASE_W-1:0]                baseline, start_baseline;
  logic                             primed, armed;
  logic [bedo_pkg::SINCE_W-1:0]     since;

  // Working registers of the current frame.
  logic signed [MONO_W-1:0]         mono;
  logic                             last;
  logic signed [POLE_W-1:0]         prod;
  logic [bedo_pkg::SQUARE_W-1:0]    sq;
  logic [bedo_pkg::ENERGY_W-1:0]    energy;
  logic [BASE_W-1:0]                bdiff, delta;
  logic                             bneg;
  logic [SCL_W-1:0]                 pl, ph;
  logic [SUM_W-1:0]                 mean;
  logic [SCL_W-1:0]                 rearm_prod, onset_prod;

  // Combinational helpers.
  logic signed [MONO_W:0]           pole_diff;
  logic signed [POLE_W:0]           pole_full;
  logic signed [POLE_W-1:0]         pole_rnd;
  logic signed [MONO_W:0]           pole_step;
  logic signed [MONO_W-1:0]         pole_base;
  logic signed [MONO_W:0]           pole_sum;
  logic [MONO_W-1:0]                s2_bits, mag;
  logic [BASE_W-1:0]                dscaled;
  logic [SUM_W:0]                   sum_add;
  logic [SCL_W+15:0]                scale_sum;
  logic [LHS_W-1:0]                 lhs;
  logic                             rearm_now, armed_eff, fire;
  logic                             chunk_end;
  logic                             div_start, div_done;
  logic [SUM_W-1:0]                 div_quot;

  // Shared multiplier of the two low-pass poles.
  always_comb begin
    if (state == bedo_pkg::ST_MUL1) begin
      pole_diff = {mono[MONO_W-1], mono} - {s1[MONO_W-1], s1};
    end else begin
      pole_diff = {s1[MONO_W-1], s1} - {s2[MONO_W-1], s2};
    end
    pole_full = pole_diff * $signed({1'b0, cfg.lowpass_coeff});
    pole_rnd  = prod + 49'sd32768;
    pole_step = (MONO_W + 1)'(pole_rnd >>> 16);
    pole_base = (state == bedo_pkg::ST_ACC1) ? s1 : s2;
    pole_sum  = {pole_base[MONO_W-1], pole_base} + pole_step;
  end

  // Energy, chunk sum and baseline arithmetic.
  always_comb begin
    s2_bits   = s2;
    mag       = s2_bits[MONO_W-1] ? (~s2_bits + 1'b1) : s2_bits;
    dscaled   = {energy, 8'd0};
    sum_add   = {1'b0, sum} + (SUM_W + 1)'(energy);
    scale_sum = {ph, 16'd0} + (SCL_W + 16)'(pl) + (SCL_W + 16)'(32'h8000_0000);
    chunk_end = last || (count == CNT_W'(MAX_CHUNK_FRAMES));
  end

  // Chunk decision on the mean energy.
  always_comb begin
    lhs       = {mean, 16'd0};
    rearm_now = !armed && (lhs < LHS_W'(rearm_prod));
    armed_eff = armed || rearm_now;
    fire      = primed && armed_eff
             && (mean > SUM_W'({cfg.silence_floor, 8'd0}))
             && (lhs > LHS_W'(onset_prod))
             && (since >= bedo_pkg::SINCE_W'(cfg.refractory_frames));
  end

  // Mean energy over the chunk.
  bedo_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quot)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bedo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshakes.
  always_comb begin
    state_next = state;
    fr_ready   = 1'b0;
    res_valid  = 1'b0;
    div_start  = 1'b0;
    case (state)
      bedo_pkg::ST_IDLE: begin
        fr_ready = 1'b1;
        if (fr_valid) begin
          state_next = bedo_pkg::ST_MUL1;
        end
      end
      bedo_pkg::ST_MUL1:   state_next = bedo_pkg::ST_ACC1;
      bedo_pkg::ST_ACC1:   state_next = bedo_pkg::ST_MUL2;
      bedo_pkg::ST_MUL2:   state_next = bedo_pkg::ST_ACC2;
      bedo_pkg::ST_ACC2:   state_next = bedo_pkg::ST_SQR;
      bedo_pkg::ST_SQR:    state_next = bedo_pkg::ST_ENERGY;
      bedo_pkg::ST_ENERGY: state_next = bedo_pkg::ST_DIFF;
      bedo_pkg::ST_DIFF:   state_next = bedo_pkg::ST_MULB;
      bedo_pkg::ST_MULB:   state_next = bedo_pkg::ST_SCALE;
      bedo_pkg::ST_SCALE:  state_next = bedo_pkg::ST_BUPD;
      bedo_pkg::ST_BUPD: begin
        state_next = chunk_end ? bedo_pkg::ST_DIV_START : bedo_pkg::ST_IDLE;
      end
      bedo_pkg::ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = bedo_pkg::ST_DIV_WAIT;
      end
      bedo_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = bedo_pkg::ST_CMP_MUL;
        end
      end
      bedo_pkg::ST_CMP_MUL: state_next = bedo_pkg::ST_DECIDE;
      bedo_pkg::ST_DECIDE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = bedo_pkg::ST_IDLE;
        end
      end
      default: state_next = bedo_pkg::ST_IDLE;
    endcase
  end

  assign res_fired = fire;

  // Datapath registers, advanced by the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1             <= '0;
      s2             <= '0;
      sum            <= '0;
      count          <= '0;
      baseline       <= '0;
      start_baseline <= '0;
      primed         <= 1'b0;
      armed          <= 1'b1;
      since          <= '1;
    end else begin
      case (state)
        bedo_pkg::ST_IDLE: begin
          mono <= frame.mono;
          last <= frame.last;
        end
        bedo_pkg::ST_MUL1, bedo_pkg::ST_MUL2: begin
          prod <= pole_full[POLE_W-1:0];
        end
        bedo_pkg::ST_ACC1: s1 <= pole_sum[MONO_W-1:0];
        bedo_pkg::ST_ACC2: s2 <= pole_sum[MONO_W-1:0];
        bedo_pkg::ST_SQR:  sq <= mag * mag;
        bedo_pkg::ST_ENERGY: begin
          energy <= bedo_pkg::ENERGY_W'((sq + 64'd8388608) >> 24);
        end
        bedo_pkg::ST_DIFF: begin
          bneg  <= (dscaled < baseline);
          bdiff <= (dscaled < baseline) ? (baseline - dscaled) : (dscaled - baseline);
          sum   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          count <= count + 1'b1;
          if (since != '1) begin
            since <= since + 1'b1;
          end
        end
        bedo_pkg::ST_MULB: begin
          pl <= bdiff * cfg.baseline_coeff[15:0];
          ph <= bdiff * cfg.baseline_coeff[31:16];
        end
        bedo_pkg::ST_SCALE: delta <= BASE_W'(scale_sum >> 32);
        bedo_pkg::ST_BUPD: begin
          baseline <= bneg ? (baseline - delta) : (baseline + delta);
        end
        bedo_pkg::ST_DIV_WAIT: begin
          if (div_done) begin
            mean <= div_quot;
          end
        end
        bedo_pkg::ST_CMP_MUL: begin
          rearm_prod <= cfg.rearm_ratio * start_baseline;
          onset_prod <= cfg.onset_ratio * start_baseline;
        end
        bedo_pkg::ST_DECIDE: begin
          if (res_ready) begin
            armed          <= fire ? 1'b0 : armed_eff;
            since          <= fire ? '0 : since;
            start_baseline <= baseline;
            primed         <= 1'b1;
            sum            <= '0;
            count          <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The divider only finishes while the sequencer waits for it.
  a_div_done_waited : assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == bedo_pkg::ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  // A delivered chunk result leaves the chunk sum and count cleared.
  a_chunk_cleared : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> ((sum == '0) && (count == '0)))
    else $error("chunk accumulators not cleared after a result");

  // The chunk count never runs past its limit.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    (state == bedo_pkg::ST_DIFF) |=> (count <= CNT_W'(MAX_CHUNK_FRAMES)))
    else $error("chunk frame count beyond its limit");

endmodule

`default_nettype wire

@@ src/bass_energy_onset_detector_top.sv @@
// Top level of the bass energy onset detector: registers, front end, back end, result stage.
//
//   Channel   Handshake             Word
//   input     push / full           sample_a, sample_b, last_frame
//   result    pop / empty           onset_fired
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each frame passes through the back-end sequencer in turn: two low-pass poles through
// one shared multiplier, the square, and a two-half baseline scaling.
// A frame that closes a chunk then waits for the one-bit-a-cycle divider that forms
// the mean energy in 50 steps, and then for the ratio products
// and the decision.
// A two-word queue lets the input side run ahead while the back end works.
// The result register frees the back end as soon as a word is popped; it stalls only
// while an earlier result is still waiting. Reset is synchronous and needs no clearing pass.
`default_nettype none

module bass_energy_onset_detector_top #(
  parameter int MAX_CHUNK_FRAMES = bedo_pkg::MAX_CHUNK_FRAMES_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   push,
  output logic                                        full,
  input  wire logic signed [bedo_pkg::SAMPLE_W-1:0]   sample_a,
  input  wire logic signed [bedo_pkg::SAMPLE_W-1:0]   sample_b,
  input  wire logic                                   last_frame,
  output logic                                        empty,
  input  wire logic                                   pop,
  output logic                                        onset_fired,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [bedo_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [bedo_pkg::CFG_DATA_W-1:0]        cfg_data
);

  bedo_pkg::cfg_t   cfg;
  bedo_pkg::frame_t frame;
  logic             fr_valid;
  logic             fr_ready;
  logic             res_valid;
  logic             res_ready;
  logic             res_fired;
  logic             out_valid;
  logic             out_fired;

  // Configuration registers, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count     <= bedo_pkg::CHANNEL_COUNT_RST;
      cfg.lowpass_coeff     <= bedo_pkg::LOWPASS_COEFF_RST;
      cfg.baseline_coeff    <= bedo_pkg::BASELINE_COEFF_RST;
      cfg.onset_ratio       <= bedo_pkg::ONSET_RATIO_RST;
      cfg.rearm_ratio       <= bedo_pkg::REARM_RATIO_RST;
      cfg.silence_floor     <= bedo_pkg::SILENCE_FLOOR_RST;
      cfg.refractory_frames <= bedo_pkg::REFRACTORY_FRAMES_RST;
    end else if (cfg_valid) begin
      case (bedo_pkg::reg_index_t'(cfg_index))
        bedo_pkg::REG_CHANNEL_COUNT:     cfg.channel_count     <= cfg_data[1:0];
        bedo_pkg::REG_LOWPASS_COEFF:     cfg.lowpass_coeff     <= cfg_data[15:0];
        bedo_pkg::REG_BASELINE_COEFF:    cfg.baseline_coeff    <= cfg_data;
        bedo_pkg::REG_ONSET_RATIO:       cfg.onset_ratio       <= cfg_data[15:0];
        bedo_pkg::REG_REARM_RATIO:       cfg.rearm_ratio       <= cfg_data[15:0];
        bedo_pkg::REG_SILENCE_FLOOR:     cfg.silence_floor     <= cfg_data[30:0];
        bedo_pkg::REG_REFRACTORY_FRAMES: cfg.refractory_frames <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: accept and mix.
  bedo_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample_a      (sample_a),
    .sample_b      (sample_b),
    .last_frame    (last_frame),
    .channel_count (cfg.channel_count),
    .fr_valid      (fr_valid),
    .fr_ready      (fr_ready),
    .frame         (frame)
  );

  // Back end: filtering, energy and onset decision.
  bedo_back #(
    .MAX_CHUNK_FRAMES (MAX_CHUNK_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fr_valid  (fr_valid),
    .fr_ready  (fr_ready),
    .frame     (frame),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_fired (res_fired)
  );

  // Result register: refilled in the same cycle that its word is popped.
  assign res_ready   = !out_valid || pop;
  assign empty       = !out_valid;
  assign onset_fired = out_fired;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_fired <= res_fired;
    end
  end

  // A result taken from the back end is on offer the next cycle.
  a_result_offered : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> !empty)
    else $error("result word lost on its way to the output");

  // A waiting result holds its value until popped.
  a_result_held : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(onset_fired)))
    else $error("waiting result changed before it was popped");

endmodule

`default_nettype wire
